// ----- hdl/fcx_pkg.sv -----
// shared constants, codes and types for the fir crossfade block
package fcx_pkg;

    localparam int MAX_TAPS    = 256;
    localparam int TAP_W       = $clog2(MAX_TAPS);
    localparam int TAPCNT_W    = 9;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_BLOCK   = 4096;
    localparam int POS_W       = 12;
    localparam int BLEN_W      = 13;
    localparam int STEP_W      = 17;
    localparam int WEIGHT_W    = 17;
    localparam int WP_W        = POS_W + STEP_W;
    localparam int UNITY       = 65536;
    localparam int DIFF_W      = SAMPLE_BITS + 1;
    localparam int COEF_W      = WEIGHT_W + 1 + DIFF_W;
    localparam int PROD_W      = COEF_W + SAMPLE_BITS;
    localparam int ACC_W       = 58;
    localparam int FRAC_SHIFT  = 31;
    localparam int Q_W         = ACC_W - FRAC_SHIFT;
    localparam int MAC_LAT     = 4;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 4;
    localparam int S_DATA_W    = 24;
    localparam int S_USER_W    = 2;

    localparam logic [WP_W-1:0]     UNITY_WP     = WP_W'(UNITY);
    localparam logic [WEIGHT_W-1:0] UNITY_W      = WEIGHT_W'(UNITY);
    localparam logic [TAPCNT_W-1:0] MAX_TAPS_CNT = TAPCNT_W'(MAX_TAPS);
    localparam logic [BLEN_W-1:0]   MAX_BLK_LEN  = BLEN_W'(MAX_BLOCK);
    localparam logic [TAP_W-1:0]    LAST_STEP    = TAP_W'(MAX_TAPS - 1);
    // pipeline stages plus the accumulate stage
    localparam logic [TAP_W-1:0]    LAST_DRAIN   = TAP_W'(MAC_LAT);
    localparam logic [ACC_W-1:0]    ROUND_HALF   = ACC_W'(64'd1 << (FRAC_SHIFT - 1));
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [Q_W-1:0] Q_MIN = ~Q_MAX;

    localparam logic [1:0] REG_TAP_COUNT    = 2'd0;
    localparam logic [1:0] REG_BLOCK_LENGTH = 2'd1;
    localparam logic [1:0] REG_FADE_STEP    = 2'd2;
    localparam logic [1:0] REG_XFADE_MODE   = 2'd3;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_WR_FROM = 2'd1,
        OP_WR_TO   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROT   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    typedef struct packed {
        logic ins;
        logic rot;
        logic wr_from;
        logic wr_to;
    } t_cell_ctrl;

    typedef struct packed {
        logic clr;
        logic act;
    } t_mac_ctrl;

endpackage

// ----- hdl/fcx_tap_cell.sv -----
// one tap cell: history sample and both coefficients, shifting or rotating with its neighbors
module fcx_tap_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  fcx_pkg::t_cell_ctrl                   i_ctrl,
    input  logic                                  i_sel,
    input  logic signed [fcx_pkg::SAMPLE_BITS-1:0] i_value,
    input  logic signed [fcx_pkg::SAMPLE_BITS-1:0] i_ins_h,
    input  logic signed [fcx_pkg::SAMPLE_BITS-1:0] i_rot_h,
    input  logic signed [fcx_pkg::SAMPLE_BITS-1:0] i_rot_f,
    input  logic signed [fcx_pkg::SAMPLE_BITS-1:0] i_rot_t,
    output logic signed [fcx_pkg::SAMPLE_BITS-1:0] o_h,
    output logic signed [fcx_pkg::SAMPLE_BITS-1:0] o_f,
    output logic signed [fcx_pkg::SAMPLE_BITS-1:0] o_t
);

    logic signed [fcx_pkg::SAMPLE_BITS-1:0] r_h;
    logic signed [fcx_pkg::SAMPLE_BITS-1:0] r_f;
    logic signed [fcx_pkg::SAMPLE_BITS-1:0] r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= '0;
        end else if (i_ctrl.ins) begin
            r_h <= i_ins_h;
        end else if (i_ctrl.rot) begin
            r_h <= i_rot_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rot) begin
            r_f <= i_rot_f;
            r_t <= i_rot_t;
        end else begin
            if (i_ctrl.wr_from && i_sel) begin
                r_f <= i_value;
            end
            if (i_ctrl.wr_to && i_sel) begin
                r_t <= i_value;
            end
        end
    end

    assign o_h = r_h;
    assign o_f = r_f;
    assign o_t = r_t;

endmodule

// ----- hdl/fcx_mac.sv -----
// pipelined blend, multiply and accumulate unit with rounding and saturation
module fcx_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fcx_pkg::t_mac_ctrl                     i_ctrl,
    input  logic [fcx_pkg::WEIGHT_W-1:0]           i_w2,
    input  logic signed [fcx_pkg::SAMPLE_BITS-1:0] i_h,
    input  logic signed [fcx_pkg::SAMPLE_BITS-1:0] i_f,
    input  logic signed [fcx_pkg::SAMPLE_BITS-1:0] i_t,
    output logic signed [fcx_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                                   o_sat
);

    logic signed [fcx_pkg::SAMPLE_BITS-1:0] r_h1, r_h2, r_h3;
    logic signed [fcx_pkg::SAMPLE_BITS-1:0] r_f1, r_f2;
    logic signed [fcx_pkg::DIFF_W-1:0]      r_d1;
    logic signed [fcx_pkg::COEF_W-1:0]      r_m2;
    logic signed [fcx_pkg::COEF_W-1:0]      r_c3;
    logic signed [fcx_pkg::PROD_W-1:0]      r_p4;
    logic signed [fcx_pkg::ACC_W-1:0]       r_acc;
    logic [3:0]                             r_act;

    logic signed [fcx_pkg::WEIGHT_W:0]      w_w2s;
    logic signed [fcx_pkg::COEF_W-1:0]      w_fsh;
    logic signed [fcx_pkg::ACC_W-1:0]       w_rnd;
    logic signed [fcx_pkg::Q_W-1:0]         w_q;

    // coef = 2^16*from + w2*(to - from) equals w1*from + w2*to
    assign w_w2s = $signed({1'b0, i_w2});
    assign w_fsh = $signed({{(fcx_pkg::COEF_W - fcx_pkg::SAMPLE_BITS - 16){r_f2[fcx_pkg::SAMPLE_BITS-1]}},
                            r_f2, 16'b0});

    always_ff @(posedge i_clk) begin
        r_h1 <= i_h;
        r_f1 <= i_f;
        r_d1 <= fcx_pkg::DIFF_W'(i_t) - fcx_pkg::DIFF_W'(i_f);
        r_h2 <= r_h1;
        r_f2 <= r_f1;
        r_m2 <= fcx_pkg::COEF_W'(w_w2s * r_d1);
        r_h3 <= r_h2;
        r_c3 <= w_fsh + r_m2;
        r_p4 <= fcx_pkg::PROD_W'(r_h3 * r_c3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= '0;
            r_acc <= '0;
        end else begin
            r_act <= {r_act[2:0], i_ctrl.act};
            if (i_ctrl.clr) begin
                r_acc <= '0;
            end else if (r_act[3]) begin
                r_acc <= r_acc + fcx_pkg::ACC_W'(r_p4);
            end
        end
    end

    assign w_rnd = r_acc + $signed(fcx_pkg::ROUND_HALF);
    assign w_q   = fcx_pkg::Q_W'(w_rnd >>> fcx_pkg::FRAC_SHIFT);

    always_comb begin
        o_sat = 1'b0;
        o_sample = w_q[fcx_pkg::SAMPLE_BITS-1:0];
        if (w_q > fcx_pkg::Q_MAX) begin
            o_sat = 1'b1;
            o_sample = fcx_pkg::Q_MAX[fcx_pkg::SAMPLE_BITS-1:0];
        end else if (w_q < fcx_pkg::Q_MIN) begin
            o_sat = 1'b1;
            o_sample = fcx_pkg::Q_MIN[fcx_pkg::SAMPLE_BITS-1:0];
        end
    end

endmodule

// ----- hdl/fir_convolution_crossfade.sv -----
// top level: fir filter over a ring of tap cells with coefficient crossfade
// a sample runs through the rotate, drain and done states to a registered result, input busy
// the ring of 256 cells rotates once past the single mac, then the mac pipeline drains
// coefficient writes and unused operation codes give no result and leave the input ready
// a new transfer is accepted while an earlier result still waits at the output
// synchronous active-low reset clears history, block position, registers and control
module fir_convolution_crossfade (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [fcx_pkg::S_DATA_W-1:0]      s_axis_tdata,  // tap_index, value
    input  logic [fcx_pkg::S_USER_W-1:0]      s_axis_tuser,  // operation
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fcx_pkg::SAMPLE_BITS-1:0]   m_axis_tdata,  // sample_out
    output logic                              m_axis_tuser,  // saturated
    output logic                              m_axis_tlast,  // block_end
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fcx_pkg::APB_AW-1:0]        paddr,
    input  logic [fcx_pkg::APB_DW-1:0]        pwdata,
    output logic [fcx_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    fcx_pkg::t_state                     r_state, n_state;
    logic [fcx_pkg::TAP_W-1:0]           r_step, n_step;
    logic [fcx_pkg::TAPCNT_W-1:0]        r_taps;
    logic [fcx_pkg::WEIGHT_W-1:0]        r_w2;
    logic                                r_blk_end;
    logic [fcx_pkg::POS_W-1:0]           r_pos;
    logic [fcx_pkg::TAPCNT_W-1:0]        r_tap_count;
    logic [fcx_pkg::BLEN_W-1:0]          r_block_length;
    logic [fcx_pkg::STEP_W-1:0]          r_fade_step;
    logic                                r_xfade;
    logic                                r_m_valid;
    logic [fcx_pkg::SAMPLE_BITS-1:0]     r_m_data;
    logic                                r_m_sat;
    logic                                r_m_last;

    fcx_pkg::t_op                        w_op;
    logic [fcx_pkg::TAP_W-1:0]           w_tap;
    logic signed [fcx_pkg::SAMPLE_BITS-1:0] w_value;
    logic                                w_in_xfer;
    logic                                w_smp_xfer;
    logic                                w_coef_xfer;
    logic                                w_cfg_wr;
    logic [fcx_pkg::WP_W-1:0]            w_wprod;
    logic [fcx_pkg::WEIGHT_W-1:0]        w_w2;
    logic [fcx_pkg::BLEN_W-1:0]          w_eff;
    logic [fcx_pkg::BLEN_W-1:0]          w_pos_inc;
    logic                                w_last;
    logic                                w_out_free;
    logic                                w_load;
    fcx_pkg::t_cell_ctrl                 w_cell_ctrl;
    fcx_pkg::t_mac_ctrl                  w_mac_ctrl;
    logic signed [fcx_pkg::SAMPLE_BITS-1:0] w_mac_sample;
    logic                                w_mac_sat;

    logic signed [fcx_pkg::SAMPLE_BITS-1:0] w_h [fcx_pkg::MAX_TAPS];
    logic signed [fcx_pkg::SAMPLE_BITS-1:0] w_f [fcx_pkg::MAX_TAPS];
    logic signed [fcx_pkg::SAMPLE_BITS-1:0] w_t [fcx_pkg::MAX_TAPS];

    assign w_op        = fcx_pkg::t_op'(s_axis_tuser);
    assign w_tap       = s_axis_tdata[fcx_pkg::TAP_W-1:0];
    assign w_value     = s_axis_tdata[fcx_pkg::TAP_W +: fcx_pkg::SAMPLE_BITS];
    assign s_axis_tready = (r_state == fcx_pkg::ST_IDLE);
    assign w_in_xfer   = s_axis_tvalid && s_axis_tready;
    assign w_smp_xfer  = w_in_xfer && (w_op == fcx_pkg::OP_SAMPLE);
    assign w_coef_xfer = w_in_xfer && ((w_op == fcx_pkg::OP_WR_FROM) ||
                                       (w_op == fcx_pkg::OP_WR_TO));

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count    <= fcx_pkg::TAPCNT_W'(1);
            r_block_length <= fcx_pkg::BLEN_W'(256);
            r_fade_step    <= fcx_pkg::STEP_W'(256);
            r_xfade        <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                fcx_pkg::REG_TAP_COUNT:    r_tap_count    <= pwdata[fcx_pkg::TAPCNT_W-1:0];
                fcx_pkg::REG_BLOCK_LENGTH: r_block_length <= pwdata[fcx_pkg::BLEN_W-1:0];
                fcx_pkg::REG_FADE_STEP:    r_fade_step    <= pwdata[fcx_pkg::STEP_W-1:0];
                fcx_pkg::REG_XFADE_MODE:   r_xfade        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fcx_pkg::REG_TAP_COUNT:    prdata = fcx_pkg::APB_DW'(r_tap_count);
            fcx_pkg::REG_BLOCK_LENGTH: prdata = fcx_pkg::APB_DW'(r_block_length);
            fcx_pkg::REG_FADE_STEP:    prdata = fcx_pkg::APB_DW'(r_fade_step);
            fcx_pkg::REG_XFADE_MODE:   prdata = fcx_pkg::APB_DW'(r_xfade);
            default:                   prdata = '0;
        endcase
    end

    // crossfade weight and block position for the accepted sample
    assign w_wprod = {{fcx_pkg::STEP_W{1'b0}}, r_pos} * {{fcx_pkg::POS_W{1'b0}}, r_fade_step};

    always_comb begin
        if (!r_xfade) begin
            w_w2 = '0;
        end else if (w_wprod > fcx_pkg::UNITY_WP) begin
            w_w2 = fcx_pkg::UNITY_W;
        end else begin
            w_w2 = w_wprod[fcx_pkg::WEIGHT_W-1:0];
        end
        if (r_block_length == '0) begin
            w_eff = fcx_pkg::BLEN_W'(1);
        end else if (r_block_length > fcx_pkg::MAX_BLK_LEN) begin
            w_eff = fcx_pkg::MAX_BLK_LEN;
        end else begin
            w_eff = r_block_length;
        end
    end

    assign w_pos_inc = {1'b0, r_pos} + fcx_pkg::BLEN_W'(1);
    assign w_last    = (w_pos_inc >= w_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_coef_xfer) begin
            r_pos <= '0;
        end else if (w_smp_xfer) begin
            r_pos <= w_last ? '0 : w_pos_inc[fcx_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_smp_xfer) begin
            r_w2      <= w_w2;
            r_blk_end <= r_xfade && w_last;
            r_taps    <= (r_tap_count > fcx_pkg::MAX_TAPS_CNT) ? fcx_pkg::MAX_TAPS_CNT
                                                               : r_tap_count;
        end
    end

    // sequencer
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_load     = (r_state == fcx_pkg::ST_DONE) && w_out_free;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            fcx_pkg::ST_IDLE: begin
                n_step = '0;
                if (w_smp_xfer) begin
                    n_state = fcx_pkg::ST_ROT;
                end
            end
            fcx_pkg::ST_ROT: begin
                n_step = r_step + fcx_pkg::TAP_W'(1);
                if (r_step == fcx_pkg::LAST_STEP) begin
                    n_state = fcx_pkg::ST_DRAIN;
                    n_step  = '0;
                end
            end
            fcx_pkg::ST_DRAIN: begin
                n_step = r_step + fcx_pkg::TAP_W'(1);
                if (r_step == fcx_pkg::LAST_DRAIN) begin
                    n_state = fcx_pkg::ST_DONE;
                end
            end
            fcx_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = fcx_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fcx_pkg::ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcx_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign w_cell_ctrl.ins     = w_smp_xfer;
    assign w_cell_ctrl.rot     = (r_state == fcx_pkg::ST_ROT);
    assign w_cell_ctrl.wr_from = w_in_xfer && (w_op == fcx_pkg::OP_WR_FROM);
    assign w_cell_ctrl.wr_to   = w_in_xfer && (w_op == fcx_pkg::OP_WR_TO);

    assign w_mac_ctrl.clr = w_smp_xfer;
    assign w_mac_ctrl.act = (r_state == fcx_pkg::ST_ROT) && ({1'b0, r_step} < r_taps);

    // ring of tap cells, cell 0 feeds the mac
    for (genvar g = 0; g < fcx_pkg::MAX_TAPS; g++) begin : g_cell
        localparam int Nxt = (g + 1) % fcx_pkg::MAX_TAPS;
        localparam logic [fcx_pkg::TAP_W-1:0] Idx = fcx_pkg::TAP_W'(g);
        logic signed [fcx_pkg::SAMPLE_BITS-1:0] w_ins;

        if (g == 0) begin : g_head
            assign w_ins = w_value;
        end else begin : g_body
            assign w_ins = w_h[g-1];
        end

        fcx_tap_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_cell_ctrl),
            .i_sel   (w_tap == Idx),
            .i_value (w_value),
            .i_ins_h (w_ins),
            .i_rot_h (w_h[Nxt]),
            .i_rot_f (w_f[Nxt]),
            .i_rot_t (w_t[Nxt]),
            .o_h     (w_h[g]),
            .o_f     (w_f[g]),
            .o_t     (w_t[g])
        );
    end

    fcx_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_mac_ctrl),
        .i_w2     (r_w2),
        .i_h      (w_h[0]),
        .i_f      (w_f[0]),
        .i_t      (w_t[0]),
        .o_sample (w_mac_sample),
        .o_sat    (w_mac_sat)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= w_mac_sample;
            r_m_sat  <= w_mac_sat;
            r_m_last <= r_blk_end;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_sat;
    assign m_axis_tlast  = r_m_last;

endmodule

// ----- hdl/fcx_checker.sv -----
// port-level checks for the fir crossfade block, bound to the top level
module fcx_port_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [fcx_pkg::S_USER_W-1:0]    s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fcx_pkg::SAMPLE_BITS-1:0] m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);

    logic w_in_xfer;
    logic w_is_sample;

    assign w_in_xfer   = s_axis_tvalid && s_axis_tready;
    assign w_is_sample = (s_axis_tuser == fcx_pkg::OP_SAMPLE);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a sample keeps the block busy for the ring pass
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && w_is_sample |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input ready too soon after a sample");

    // coefficient writes and unused codes leave the input ready in the next cycle
    a_ready_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && !w_is_sample |=> s_axis_tready)
        else $error("input not ready after a non-sample transfer");

    // a result appears only at the end of a busy pass
    a_result_from_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result without a finished pass");

endmodule

bind fir_convolution_crossfade fcx_port_checker u_fcx_checker (.*);

// ----- dv/fcx_checker.sv -----
// checker for the fir crossfade block: tracks state, predicts each filtered sample, compares
module fcx_checker import fcx_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    input  logic [S_DATA_W-1:0]     i_s_tdata,     // tap_index, value
    input  logic [S_USER_W-1:0]     i_s_tuser,     // operation
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    input  logic [SAMPLE_BITS-1:0]  i_m_tdata,     // sample_out
    input  logic                    i_m_tuser,     // saturated
    input  logic                    i_m_tlast,     // block_end
    input  logic                    i_psel,
    input  logic                    i_penable,
    input  logic                    i_pwrite,
    input  logic                    i_pready,
    input  logic [APB_AW-1:0]       i_paddr,
    input  logic [APB_DW-1:0]       i_pwdata,
    input  logic [APB_DW-1:0]       i_prdata,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_results,
    output int                      o_saturations,
    output int                      o_block_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_out;
        logic                   saturated;
        logic                   block_end;
    } t_filtered;

    logic signed [SAMPLE_BITS-1:0] hist      [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] coef_from [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] coef_to   [MAX_TAPS];
    logic [POS_W-1:0]    blk_pos;
    logic [TAPCNT_W-1:0] r_taps;
    logic [BLEN_W-1:0]   r_blen;
    logic [STEP_W-1:0]   r_step;
    logic                r_xfade;

    t_filtered expected_filtered [$];
    int n_fail;
    int n_results;
    int n_sat;
    int n_blk;

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (n_fail < PRINT_CAP) begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        end
        n_fail++;
    endtask

    function automatic t_filtered filter_sample(input logic signed [SAMPLE_BITS-1:0] x);
        t_filtered res;
        longint    w1;
        longint    w2;
        longint    coef;
        longint    acc;
        longint    q;
        longint    hi;
        longint    lo;
        int        n_taps;
        int        eff_len;
        int        k;
        bit        last;
        for (k = MAX_TAPS - 1; k > 0; k--) begin
            hist[k] = hist[k-1];
        end
        hist[0] = x;
        w2 = 0;
        if (r_xfade) begin
            w2 = longint'(blk_pos) * longint'(r_step);
            if (w2 > UNITY) begin
                w2 = UNITY;
            end
        end
        w1 = UNITY - w2;
        n_taps = (r_taps > MAX_TAPS_CNT) ? MAX_TAPS : int'(r_taps);
        acc = 0;
        for (k = 0; k < n_taps; k++) begin
            coef = w1 * longint'(coef_from[k]) + w2 * longint'(coef_to[k]);
            acc += longint'(hist[k]) * coef;
        end
        q = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        res.saturated = 1'b0;
        if (q > hi) begin
            q = hi;
            res.saturated = 1'b1;
        end
        if (q < lo) begin
            q = lo;
            res.saturated = 1'b1;
        end
        if (r_blen == '0) begin
            eff_len = 1;
        end else if (r_blen > MAX_BLK_LEN) begin
            eff_len = MAX_BLOCK;
        end else begin
            eff_len = int'(r_blen);
        end
        last = (int'(blk_pos) + 1) >= eff_len;
        blk_pos = last ? '0 : blk_pos + 1'b1;
        res.sample_out = q[SAMPLE_BITS-1:0];
        res.block_end = r_xfade && last;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_filtered         want;
        logic [APB_DW-1:0] rd_want;
        int                k;
        if (!i_rst_n) begin
            for (k = 0; k < MAX_TAPS; k++) begin
                hist[k] = '0;
                coef_from[k] = '0;
                coef_to[k] = '0;
            end
            blk_pos = '0;
            r_taps = TAPCNT_W'(1);
            r_blen = BLEN_W'(256);
            r_step = STEP_W'(256);
            r_xfade = 1'b0;
            expected_filtered.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                n_results++;
                if (i_m_tuser) n_sat++;
                if (i_m_tlast) n_blk++;
                if (expected_filtered.size() == 0) begin
                    report_mismatch("result with no sample waiting", 0,
                                    longint'(signed'(i_m_tdata)));
                end else begin
                    want = expected_filtered.pop_front();
                    if (i_m_tdata !== want.sample_out) begin
                        report_mismatch("sample_out", longint'(signed'(want.sample_out)),
                                        longint'(signed'(i_m_tdata)));
                    end
                    if (i_m_tuser !== want.saturated) begin
                        report_mismatch("saturated", want.saturated, i_m_tuser);
                    end
                    if (i_m_tlast !== want.block_end) begin
                        report_mismatch("block_end", want.block_end, i_m_tlast);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                case (t_op'(i_s_tuser))
                    OP_SAMPLE: begin
                        expected_filtered.push_back(
                            filter_sample(i_s_tdata[TAP_W +: SAMPLE_BITS]));
                    end
                    OP_WR_FROM: begin
                        coef_from[i_s_tdata[TAP_W-1:0]] = i_s_tdata[TAP_W +: SAMPLE_BITS];
                        blk_pos = '0;
                    end
                    OP_WR_TO: begin
                        coef_to[i_s_tdata[TAP_W-1:0]] = i_s_tdata[TAP_W +: SAMPLE_BITS];
                        blk_pos = '0;
                    end
                    default: ;
                endcase
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[3:2])
                        REG_TAP_COUNT:    r_taps = i_pwdata[TAPCNT_W-1:0];
                        REG_BLOCK_LENGTH: r_blen = i_pwdata[BLEN_W-1:0];
                        REG_FADE_STEP:    r_step = i_pwdata[STEP_W-1:0];
                        REG_XFADE_MODE:   r_xfade = i_pwdata[0];
                        default: ;
                    endcase
                end else begin
                    case (i_paddr[3:2])
                        REG_TAP_COUNT:    rd_want = APB_DW'(r_taps);
                        REG_BLOCK_LENGTH: rd_want = APB_DW'(r_blen);
                        REG_FADE_STEP:    rd_want = APB_DW'(r_step);
                        REG_XFADE_MODE:   rd_want = APB_DW'(r_xfade);
                        default:          rd_want = '0;
                    endcase
                    if (i_prdata !== rd_want) begin
                        report_mismatch("register read", rd_want, i_prdata);
                    end
                end
            end
        end
        o_pending <= expected_filtered.size();
        o_fail_count <= n_fail;
        o_results <= n_results;
        o_saturations <= n_sat;
        o_block_ends <= n_blk;
    end

endmodule

// ----- dv/tb_fir_convolution_crossfade.sv -----
// testbench top: stimulus and register settings for the fir crossfade block, and the verdict
module tb_fir_convolution_crossfade import fcx_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_SETTLE    = 4;
    localparam int END_SETTLE     = 300;
    localparam int RX_HOLD_CYCLES = 3000;
    localparam int LIMIT_NS       = 5_000_000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    logic [S_DATA_W-1:0]    s_axis_tdata = '0;     // tap_index, value
    logic [S_USER_W-1:0]    s_axis_tuser = '0;     // operation
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire [SAMPLE_BITS-1:0]  m_axis_tdata;          // sample_out
    wire                    m_axis_tuser;          // saturated
    wire                    m_axis_tlast;          // block_end
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    wire  [APB_DW-1:0]      prdata;
    wire                    pready;

    int fail_count;
    int pending;
    int results_seen;
    int sat_seen;
    int blk_end_seen;
    int items_sent;
    int samples_sent;
    int settings_run;
    bit calm = 1'b0;
    bit rx_hold_req = 1'b0;

    fir_convolution_crossfade u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fcx_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_m_tlast     (m_axis_tlast),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results_seen),
        .o_saturations (sat_seen),
        .o_block_ends  (blk_end_seen)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [SAMPLE_BITS-1:0] pick_coef(input bit allow_extreme);
        if (allow_extreme) begin
            case ($urandom_range(7))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                default: ;
            endcase
        end
        return 16'($urandom_range(4095)) - 16'd2048;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_item(input t_op op, input logic [TAP_W-1:0] idx,
                             input logic [SAMPLE_BITS-1:0] val);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {val, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (op == OP_SAMPLE) samples_sent++;
        if (!calm && $urandom_range(99) < 25) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_access(input logic [1:0] idx, input bit wr, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input int taps, input int blen, input int step, input bit xfade);
        drain_results();
        cfg_access(REG_TAP_COUNT, 1'b1, APB_DW'(taps));
        cfg_access(REG_BLOCK_LENGTH, 1'b1, APB_DW'(blen));
        cfg_access(REG_FADE_STEP, 1'b1, APB_DW'(step));
        cfg_access(REG_XFADE_MODE, 1'b1, APB_DW'(xfade));
        cfg_access(REG_TAP_COUNT, 1'b0, '0);
        cfg_access(REG_BLOCK_LENGTH, 1'b0, '0);
        cfg_access(REG_FADE_STEP, 1'b0, '0);
        cfg_access(REG_XFADE_MODE, 1'b0, '0);
        settings_run++;
    endtask

    // mostly sample runs so blocks complete, with rare coefficient bursts and unused codes
    task automatic run_phase(input int taps, input int blen, input int step, input bit xfade,
                             input int n_items, input bit rx_hold, input bit pause_mid);
        int i;
        int b;
        int burst;
        int roll;
        bit paused;
        apply_settings(taps, blen, step, xfade);
        if (rx_hold) rx_hold_req = 1'b1;
        i = 0;
        paused = 1'b0;
        while (i < n_items) begin
            if (pause_mid && !paused && i >= n_items / 2) begin
                drain_results();
                paused = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 4) begin
                burst = $urandom_range(1, 4);
                for (b = 0; b < burst; b++) begin
                    send_item($urandom_range(1) ? OP_WR_TO : OP_WR_FROM,
                              TAP_W'($urandom_range(255)), pick_coef(1'b1));
                end
                i += burst;
            end else if (roll < 6) begin
                send_item(OP_NONE, TAP_W'($urandom_range(255)), 16'($urandom_range(65535)));
                i++;
            end else begin
                send_item(OP_SAMPLE, TAP_W'($urandom_range(255)), pick_sample());
                i++;
            end
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 25);
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout with %0d filtered samples still outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int k;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both coefficient tables are undefined until written: fill them before any sample
        for (k = 0; k < MAX_TAPS; k++) begin
            send_item(OP_WR_FROM, TAP_W'(k), pick_coef(1'b0));
            send_item(OP_WR_TO, TAP_W'(k), pick_coef(1'b0));
        end
        drain_results();
        cfg_access(REG_TAP_COUNT, 1'b0, '0);
        cfg_access(REG_BLOCK_LENGTH, 1'b0, '0);
        cfg_access(REG_FADE_STEP, 1'b0, '0);
        cfg_access(REG_XFADE_MODE, 1'b0, '0);

        // reset settings: one tap, plain mode, sample extremes and the unused code
        send_item(OP_SAMPLE, 8'hFF, 16'h7FFF);
        send_item(OP_SAMPLE, 8'h00, 16'h8000);
        send_item(OP_NONE, 8'hA5, 16'h5A5A);

        // zero block length acts as one, so every sample ends a block; the output clips at the top
        apply_settings(4, 0, UNITY, 1'b1);
        for (k = 0; k < 4; k++) begin
            send_item(OP_WR_FROM, TAP_W'(k), 16'h7FFF);
        end
        send_item(OP_WR_TO, 8'hFF, 16'h8000);
        send_item(OP_SAMPLE, 8'h3C, 16'h7FFF);
        send_item(OP_SAMPLE, 8'hC3, 16'h7FFF);
        send_item(OP_SAMPLE, 8'h00, 16'h8000);
        send_item(OP_SAMPLE, 8'hFF, 16'h8000);
        send_item(OP_SAMPLE, 8'h00, 16'h0000);

        // no taps at all
        apply_settings(0, 2, UNITY, 1'b1);
        send_item(OP_SAMPLE, 8'h00, 16'h7FFF);

        // block of two: weight zero, then the full second set
        apply_settings(1, 2, UNITY, 1'b1);
        send_item(OP_WR_TO, 8'h00, 16'h8000);
        send_item(OP_SAMPLE, 8'h00, 16'h7FFF);
        send_item(OP_SAMPLE, 8'h00, 16'h7FFF);

        run_phase(16, 8, 8192, 1'b1, 50, 1'b0, 1'b0);
        calm = 1'b1;
        run_phase(256, 3, 21845, 1'b1, 40, 1'b0, 1'b0);
        calm = 1'b0;
        run_phase(511, 8191, 16, 1'b1, 30, 1'b1, 1'b0);
        run_phase(0, 5, 131071, 1'b1, 15, 1'b0, 1'b0);
        run_phase(1, 2, UNITY, 1'b1, 20, 1'b0, 1'b1);
        run_phase(64, 16, 0, 1'b1, 40, 1'b0, 1'b0);
        run_phase(200, 7, 9362, 1'b0, 40, 1'b0, 1'b0);
        run_phase(256, MAX_BLOCK, UNITY, 1'b1, 30, 1'b0, 1'b0);
        run_phase(33, 12, 5461, 1'b1, 50, 1'b0, 1'b0);
        for (k = 0; k < 3; k++) begin
            run_phase($urandom_range(300), $urandom_range(1, 16), $urandom_range(131071),
                      1'b1, 30, 1'b0, 1'b0);
        end

        drain_results();
        repeat (END_SETTLE) @(posedge i_clk);
        $display("sent %0d transfers (%0d samples) across %0d register settings",
                 items_sent, samples_sent, settings_run);
        $display("checked %0d filtered samples: %0d clipped, %0d closing a crossfade block",
                 results_seen, sat_seen, blk_end_seen);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/fcx_pkg.sv
hdl/fcx_tap_cell.sv
hdl/fcx_mac.sv
hdl/fir_convolution_crossfade.sv
hdl/fcx_checker.sv
dv/fcx_checker.sv
dv/tb_fir_convolution_crossfade.sv
